FILE: rtl/core/cbrf_pkg.sv
`default_nettype none

package cbrf_pkg;

  // Fixed-point format and loop bound defaults
  localparam int FRAC_BITS          = 26;
  localparam int MAX_ROUNDS_DEFAULT = 64;

  // Configuration register indexes
  localparam logic [1:0] CFG_TOLERANCE  = 2'd0;
  localparam logic [1:0] CFG_SCAN_STEP  = 2'd1;
  localparam logic [1:0] CFG_SCAN_LIMIT = 2'd2;

  // Configuration reset values
  localparam logic [30:0] TOLERANCE_RESET  = 31'd6711;
  localparam logic [30:0] SCAN_STEP_RESET  = 31'd33554432;
  localparam logic [30:0] SCAN_LIMIT_RESET = 31'd671088640;

  // Largest positive raw value at which 4x^2 - 3 is still not positive
  function automatic logic [31:0] neg_bound_f(input int frac);
    logic [63:0] v;
    logic [63:0] trial;
    logic [31:0] res;
    res = '0;
    v   = '0;
    if (frac >= 32) begin
      return '1;
    end
    v = 64'd3 << (2 * frac - 2);
    for (int b = 31; b >= 0; b--) begin
      trial = {32'd0, res | (32'd1 << b)};
      if (trial * trial <= v) begin
        res = res | (32'd1 << b);
      end
    end
    return res;
  endfunction

  localparam logic [31:0] NEG_BOUND = neg_bound_f(FRAC_BITS);

  typedef enum logic [1:0] {
    STAT_CONVERGED  = 2'd0,
    STAT_SAME_SIGN  = 2'd1,
    STAT_NO_BRACKET = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SG_ZERO = 2'd0,
    SG_POS  = 2'd1,
    SG_NEG  = 2'd2
  } sgn_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCAN,
    ST_SIGNS,
    ST_BISECT,
    ST_FINAL
  } ctrl_state_t;

  typedef struct packed {
    logic                action;
    logic signed [31:0]  left_end;
    logic signed [31:0]  right_end;
  } item_t;

  typedef struct packed {
    logic signed [31:0]  root;
    logic signed [31:0]  bracket_left;
    logic signed [31:0]  bracket_right;
    logic        [31:0]  rounds_total;
    logic        [1:0]   status;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    scan_take;
    logic    round;
    logic    finish;
    status_t code;
  } cbrf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic scan_ok;
    logic same_sign;
    logic go;
    logic mid_zero;
  } cbrf_sts_t;

  // Exact sign of 4x^3 - 3x from the raw value
  function automatic sgn_t sign_of(input logic signed [31:0] x);
    logic [31:0] ax;
    logic        big;
    ax  = x[31] ? (~x + 32'd1) : x;
    big = (ax > NEG_BOUND);
    if (x == '0) begin
      return SG_ZERO;
    end
    if (x[31] == big) begin
      return SG_NEG;
    end
    return SG_POS;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbrf_ctrl.sv
`default_nettype none

module cbrf_ctrl
  import cbrf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      action,
  input  wire cbrf_sts_t sts,
  output logic           busy,
  output cbrf_cmd_t      cmd
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = STAT_CONVERGED;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = action ? ST_DIVIDE : ST_SIGNS;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_ok) begin
          cmd.scan_take = 1'b1;
          state_next    = ST_SIGNS;
        end else begin
          cmd.finish = 1'b1;
          cmd.code   = STAT_NO_BRACKET;
          state_next = ST_IDLE;
        end
      end
      ST_SIGNS: begin
        if (sts.same_sign) begin
          cmd.finish = 1'b1;
          cmd.code   = STAT_SAME_SIGN;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_BISECT;
        end
      end
      ST_BISECT: begin
        if (sts.go) begin
          cmd.round = 1'b1;
          if (sts.mid_zero) begin
            state_next = ST_FINAL;
          end
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.finish = 1'b1;
        cmd.code   = STAT_CONVERGED;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state != ST_IDLE))
    else $error("accepted item did not leave idle");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE))
    else $error("finish did not return to idle");

endmodule

`default_nettype wire

FILE: rtl/core/cbrf_datapath.sv
`default_nettype none

module cbrf_datapath
  import cbrf_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire item_t       item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire cbrf_cmd_t   cmd,
  output cbrf_sts_t        sts,
  output result_t          result,
  output logic             done
);

  localparam int RND_W = $clog2(MAX_ROUNDS + 1);

  logic [30:0]        tolerance;
  logic [30:0]        scan_step;
  logic [30:0]        scan_limit;
  logic signed [31:0] held_root;
  logic [31:0]        round_count;
  logic signed [31:0] lft;
  logic signed [31:0] rgt;
  logic signed [31:0] start_l;
  logic signed [31:0] start_r;
  logic [RND_W-1:0]   rnd;
  logic [31:0]        rem;
  logic [4:0]         cnt;

  logic [32:0]        trial;
  logic [33:0]        trial_sub;
  logic [31:0]        lo;
  logic [32:0]        hi;
  logic signed [32:0] diff;
  logic signed [32:0] sum;
  logic signed [31:0] mid;
  sgn_t               sg_l;
  sgn_t               sg_r;
  sgn_t               sg_m;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance  <= TOLERANCE_RESET;
      scan_step  <= SCAN_STEP_RESET;
      scan_limit <= SCAN_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOLERANCE:  tolerance  <= cfg_data;
        CFG_SCAN_STEP:  scan_step  <= cfg_data;
        CFG_SCAN_LIMIT: scan_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Restoring divide step on the constant bound: only the remainder is kept
  assign trial     = {rem, NEG_BOUND[cnt]};
  assign trial_sub = {1'b0, trial} - {3'd0, scan_step};

  // Bracket from the scan: largest multiple of the step not above the bound
  assign lo = NEG_BOUND - rem;
  assign hi = {1'b0, lo} + {2'd0, scan_step};

  // Bisection arithmetic
  assign diff = {rgt[31], rgt} - {lft[31], lft};
  assign sum  = {lft[31], lft} + {rgt[31], rgt};
  assign mid  = sum[32:1];
  assign sg_l = sign_of(lft);
  assign sg_r = sign_of(rgt);
  assign sg_m = sign_of(mid);

  // Status to the controller
  always_comb begin
    sts.div_last  = (cnt == 5'd0);
    sts.scan_ok   = (scan_step != '0) && (NEG_BOUND >= {1'b0, scan_step}) &&
                    (lo <= {1'b0, scan_limit}) && (hi <= 33'h07FFFFFFF);
    sts.same_sign = (sg_l != SG_ZERO) && (sg_l == sg_r);
    sts.go        = !diff[32] && (diff[31:0] >= {1'b0, tolerance}) &&
                    (rnd < RND_W'(MAX_ROUNDS));
    sts.mid_zero  = (sg_m == SG_ZERO);
  end

  // Working bracket, divider and round counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lft     <= item.left_end;
      rgt     <= item.right_end;
      start_l <= item.left_end;
      start_r <= item.right_end;
      rem     <= '0;
      cnt     <= 5'd31;
    end
    if (cmd.div_step) begin
      rem <= trial_sub[33] ? trial[31:0] : trial_sub[31:0];
      cnt <= cnt - 5'd1;
    end
    if (cmd.scan_take) begin
      lft     <= lo;
      rgt     <= hi[31:0];
      start_l <= lo;
      start_r <= hi[31:0];
    end
    if (cmd.round) begin
      if (sg_m == SG_ZERO) begin
        lft <= mid;
        rgt <= mid;
      end else if (sg_l != SG_ZERO && sg_l != sg_m) begin
        rgt <= mid;
      end else begin
        lft <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (cmd.load) begin
      rnd <= '0;
    end else if (cmd.round) begin
      rnd <= rnd + RND_W'(1);
    end
  end

  // Cumulative round total and held root
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= '0;
      held_root   <= '0;
    end else begin
      if (cmd.round && round_count != '1) begin
        round_count <= round_count + 32'd1;
      end
      if (cmd.finish && cmd.code == STAT_CONVERGED) begin
        held_root <= mid;
      end
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.rounds_total <= round_count;
      result.status       <= cmd.code;
      case (cmd.code)
        STAT_CONVERGED: begin
          result.root          <= mid;
          result.bracket_left  <= start_l;
          result.bracket_right <= start_r;
        end
        STAT_SAME_SIGN: begin
          result.root          <= held_root;
          result.bracket_left  <= start_l;
          result.bracket_right <= start_r;
        end
        default: begin
          result.root          <= held_root;
          result.bracket_left  <= '0;
          result.bracket_right <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  a_round_cap: assert property (@(posedge clk) disable iff (rst)
    rnd <= RND_W'(MAX_ROUNDS))
    else $error("round counter beyond cap");

  a_root_held: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.root == held_root))
    else $error("reported root differs from held root");

endmodule

`default_nettype wire

FILE: rtl/core/cubic_bisection_root_finder_top.sv
`default_nettype none

// Channel    Handshake           Payload
// input      start / busy        item   (action, left_end, right_end)
// result     done (1-cycle)      result (root, bracket_left, bracket_right,
//                                        rounds_total, status)
// config     cfg_we              cfg_index, cfg_data
//
// An item is taken when start is high and busy is low; busy holds until the
// result is registered. Same signs end after the sign check; a bisection adds
// the rounds and a final state (an exact midpoint root stops the rounds);
// a scan adds 32 divider steps and a check; no bracket ends there. One round
// per cycle, at most MAX_ROUNDS. Synchronous reset restores config and clears
// held root and round total; done is a one-cycle strobe the receiver can't stall.

module cubic_bisection_root_finder_top
  import cbrf_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  cbrf_cmd_t cmd;
  cbrf_sts_t sts;

  cbrf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .sts    (sts),
    .busy   (busy),
    .cmd    (cmd)
  );

  cbrf_datapath #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result),
    .done      (done)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cbrf_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam longint S32_MIN  = -(longint'(1) << 31);
  localparam longint S32_MAX  = (longint'(1) << 31) - 1;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        busy;
  item_t       item      = '0;
  logic        done;
  result_t     result;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_TOLERANCE;
  logic [30:0] cfg_data  = '0;

  // Own copy of the configuration and the running state
  logic [30:0]        tol_reg     = TOLERANCE_RESET;
  logic [30:0]        step_reg    = SCAN_STEP_RESET;
  logic [30:0]        limit_reg   = SCAN_LIMIT_RESET;
  logic signed [31:0] last_root   = '0;
  logic [31:0]        round_total = '0;
  longint             root_bound  = 0;

  item_t   items_queued[$];
  result_t roots_due[$];
  int      errors       = 0;
  int      stall_cycles = 0;
  bit      quiet        = 1'b0;

  cubic_bisection_root_finder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Largest raw magnitude at which 4x^2 - 3 is still not positive
  function automatic longint find_bound();
    longint v, lo, hi, mid;
    v  = longint'(3) << (2 * FRAC_BITS - 2);
    lo = 0;
    hi = longint'(1) << 31;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Exact sign of 4x^3 - 3x from the raw value
  function automatic int cubic_sign(longint x);
    longint ax;
    ax = (x < 0) ? -x : x;
    if (x == 0) return 0;
    if (x > 0) return (ax > root_bound) ? 1 : -1;
    return (ax > root_bound) ? -1 : 1;
  endfunction

  // Work out the result of one item and advance the held root and round total
  function automatic result_t predict_root(item_t it);
    result_t res;
    longint  l, r, mid, s, k, lo, hi, tol;
    int      fl, fr, fm, rounds;
    bit      found;
    res.root          = last_root;
    res.bracket_left  = '0;
    res.bracket_right = '0;
    res.status        = STAT_CONVERGED;
    found  = 1'b1;
    rounds = 0;
    tol    = {33'd0, tol_reg};
    l      = 0;
    r      = 0;
    if (it.action) begin
      // Only the stride holding the positive root can be the first one found
      found = 1'b0;
      s     = {33'd0, step_reg};
      if (s != 0) begin
        k = root_bound / s;
        if (k >= 1 && k * s <= {33'd0, limit_reg}) begin
          lo = k * s;
          hi = lo + s;
          if (hi <= S32_MAX) begin
            l     = lo;
            r     = hi;
            found = 1'b1;
          end
        end
      end
    end else begin
      l = {{32{it.left_end[31]}}, it.left_end};
      r = {{32{it.right_end[31]}}, it.right_end};
    end
    if (!found) begin
      res.status = STAT_NO_BRACKET;
    end else begin
      res.bracket_left  = l[31:0];
      res.bracket_right = r[31:0];
      fl = cubic_sign(l);
      fr = cubic_sign(r);
      if (fl * fr > 0) begin
        res.status = STAT_SAME_SIGN;
      end else begin
        // Halve the bracket; an exact zero at the midpoint closes it
        while ((r - l) >= tol && rounds < MAX_ROUNDS_DEFAULT) begin
          mid = (l + r) >>> 1;
          rounds++;
          if (round_total != 32'hFFFF_FFFF) round_total++;
          fm = cubic_sign(mid);
          if (fm == 0) begin
            l = mid;
            r = mid;
            break;
          end
          if (cubic_sign(l) * fm < 0) r = mid;
          else l = mid;
        end
        mid       = (l + r) >>> 1;
        res.root  = mid[31:0];
        last_root = mid[31:0];
      end
    end
    res.rounds_total = round_total;
    return res;
  endfunction

  task automatic add_item(bit act, longint l, longint r);
    item_t it;
    it.action    = act;
    it.left_end  = l[31:0];
    it.right_end = r[31:0];
    items_queued.push_back(it);
  endtask

  // Half are brackets around one of the three roots; the rest scans, brackets past the outer roots and noise
  function automatic item_t random_item();
    item_t  it;
    longint c, span, l, r, t;
    int     kind;
    it.action    = 1'b0;
    it.left_end  = $urandom();
    it.right_end = $urandom();
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      it.action = 1'b1;
    end else if (kind < 7) begin
      case ($urandom_range(0, 2))
        0:       c = -root_bound;
        1:       c = 0;
        default: c = root_bound;
      endcase
      span = (longint'(1) << $urandom_range(0, 31)) - 1;
      l = c - (longint'($urandom()) & span);
      r = c + (longint'($urandom()) & span);
      if (l < S32_MIN) l = S32_MIN;
      if (r > S32_MAX) r = S32_MAX;
      it.left_end  = l[31:0];
      it.right_end = r[31:0];
    end else if (kind == 7) begin
      l = root_bound + 1 + (longint'($urandom()) & 64'h3FFF_FFFF);
      r = l + (longint'($urandom()) & 64'h0FFF_FFFF);
      if ($urandom_range(0, 1)) begin
        t = l;
        l = -r;
        r = -t;
      end
      it.left_end  = l[31:0];
      it.right_end = r[31:0];
    end else begin
      it.action = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  task automatic set_reg(logic [1:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_TOLERANCE) tol_reg = val;
    else if (idx == CFG_SCAN_STEP) step_reg = val;
    else if (idx == CFG_SCAN_LIMIT) limit_reg = val;
  endtask

  task automatic configure(logic [30:0] tol, logic [30:0] step, logic [30:0] limit);
    set_reg(CFG_TOLERANCE, tol);
    set_reg(CFG_SCAN_STEP, step);
    set_reg(CFG_SCAN_LIMIT, limit);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued item has been taken and its result has come
  task automatic settle();
    while (items_queued.size() != 0 || start || roots_due.size() != 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    repeat (n) items_queued.push_back(random_item());
    settle();
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Drive items from the queue, with random gaps unless quiet
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        roots_due.push_back(predict_root(item));
      end
      if (!start || !busy) begin
        if (items_queued.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
          item  <= items_queued.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (roots_due.size() == 0) begin
        report("result with nothing due", result.root, '0);
      end else begin
        want = roots_due.pop_front();
        if (result.root !== want.root)
          report("root", result.root, want.root);
        if (result.bracket_left !== want.bracket_left)
          report("bracket_left", result.bracket_left, want.bracket_left);
        if (result.bracket_right !== want.bracket_right)
          report("bracket_right", result.bracket_right, want.bracket_right);
        if (result.rounds_total !== want.rounds_total)
          report("rounds_total", result.rounds_total, want.rounds_total);
        if (result.status !== want.status)
          report("status", {30'd0, result.status}, {30'd0, want.status});
      end
    end
  end

  // Count cycles in which nothing moves
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    root_bound = find_bound();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset configuration
    add_item(1'b1, 0, 0);
    add_item(1'b1, -1, -1);
    add_item(1'b0, S32_MIN, S32_MAX);
    add_item(1'b0, 0, longint'(1) << FRAC_BITS);
    add_item(1'b0, -(longint'(1) << FRAC_BITS), longint'(1) << FRAC_BITS);
    add_item(1'b0, longint'(1) << FRAC_BITS, longint'(2) << FRAC_BITS);
    add_item(1'b0, -(longint'(2) << FRAC_BITS), -(longint'(1) << FRAC_BITS));
    add_item(1'b0, 5, -5);
    add_item(1'b0, root_bound, root_bound + 1);
    add_item(1'b0, S32_MAX, S32_MAX);
    add_item(1'b0, S32_MIN, S32_MIN);
    add_item(1'b0, S32_MIN, 0);
    add_item(1'b0, 0, 0);
    add_item(1'b0, -root_bound - 1000, -root_bound + 1000);
    add_item(1'b0, root_bound - 500000, root_bound + 700000);
    add_item(1'b0, 1, S32_MAX);
    add_item(1'b0, -1, 1);
    add_item(1'b0, -3, -1);
    settle();

    // Zero tolerance runs to the round cap; scan limit right at the stride
    configure('0, 31'd1, root_bound[30:0]);
    add_item(1'b0, S32_MIN, S32_MAX);
    add_item(1'b0, root_bound, root_bound + 1);
    add_item(1'b1, 0, 0);
    random_phase(150);

    // Widest tolerance, a stride too big to find anything, zero scan bound
    configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, '0);
    random_phase(150);

    // Zero scan step, with no gaps between items
    quiet = 1'b1;
    configure(31'd1, '0, 31'h7FFF_FFFF);
    random_phase(150);
    quiet = 1'b0;

    // Random settings
    for (int p = 0; p < 6; p++) begin
      configure(($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 20000)),
                ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                            : 31'($urandom_range(1 << 20, 1 << 27)),
                ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                            : 31'($urandom_range(0, 1 << 30)));
      random_phase(160);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: cubic_bisection_root_finder_top.f
rtl/core/cbrf_pkg.sv
rtl/core/cbrf_ctrl.sv
rtl/core/cbrf_datapath.sv
rtl/core/cubic_bisection_root_finder_top.sv
sim/testbench.sv
